>>> hw/rtl/pafk_pkg.sv
package pafk_pkg;

  localparam int ANGLE_W     = 15;
  localparam int SUM_ANGLE_W = 17;
  localparam int LEN_W       = 16;
  localparam int POS_W       = 19;
  localparam int ORIENT_W    = 17;
  localparam int TRIG_W      = 18;
  localparam int NUM_LINKS   = 3;

  // Angle LSB is 2^-ANGLE_FRAC_BITS radian.
  localparam int ANGLE_FRAC_BITS = 12;

  // round(2^32/pi), round(pi*2^30), round(2^16*64*180/pi)
  localparam logic [31:0] INV_PI_Q32 = 32'd1367130551;
  localparam logic [31:0] PI_Q30     = 32'd3373259426;
  localparam logic [27:0] DEG64_Q16  = 28'd240315917;
  localparam logic [30:0] ONE_Q30    = 31'h4000_0000;

  // Stages inside one sine/cosine lane.
  localparam int SC_STAGES = 18;
  // Input register, sine/cosine lanes, products, sum and round.
  localparam int PIPE_DEPTH = SC_STAGES + 3;

  typedef enum logic [1:0] {
    REG_FIRST_LINK  = 2'd0,
    REG_SECOND_LINK = 2'd1,
    REG_THIRD_LINK  = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [1:0] quad;
    logic       swap;
  } octant_t;

endpackage

>>> hw/rtl/pafk_pipe_ctrl.sv
module pafk_pipe_ctrl #(
  parameter int DEPTH = pafk_pkg::PIPE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             out_ready,
  output logic [DEPTH-1:0] en,
  output logic [DEPTH-1:0] valid
);

  // A stage loads when it is empty or the stage after it moves on.
  always_comb begin
    en[DEPTH-1] = !valid[DEPTH-1] || out_ready;
    for (int i = DEPTH - 2; i >= 0; i--) begin
      en[i] = !valid[i] || en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (en[0]) begin
        valid[0] <= in_valid;
      end
      for (int i = 1; i < DEPTH; i++) begin
        if (en[i]) begin
          valid[i] <= valid[i-1];
        end
      end
    end
  end

endmodule

>>> hw/rtl/pafk_taylor_step.sv
module pafk_taylor_step #(
  parameter int   DS  = 6,
  parameter int   DC  = 2,
  parameter logic NEG = 1'b1
) (
  input  logic               clk,
  input  logic [1:0]         en,
  input  logic [30:0]        ts_in,
  input  logic [30:0]        tc_in,
  input  logic [29:0]        x2_in,
  input  logic signed [31:0] as_in,
  input  logic signed [31:0] ac_in,
  output logic [30:0]        ts_out,
  output logic [30:0]        tc_out,
  output logic [29:0]        x2_out,
  output logic signed [31:0] as_out,
  output logic signed [31:0] ac_out
);

  // Exact floor division of values below 2^30 by a reciprocal multiply.
  localparam int LS = $clog2(DS);
  localparam int LC = $clog2(DC);
  localparam logic [31:0] MS = 32'(((64'd1 << (30 + LS)) + 64'(DS) - 64'd1) / DS);
  localparam logic [31:0] MC = 32'(((64'd1 << (30 + LC)) + 64'(DC) - 64'd1) / DC);

  logic [60:0]        ps_full, pc_full;
  logic [30:0]        ps, pc;
  logic [29:0]        x2_mid;
  logic signed [31:0] as_mid, ac_mid;
  logic [62:0]        qs_full, qc_full;
  logic [30:0]        qs, qc;

  assign ps_full = 61'(ts_in) * 61'(x2_in);
  assign pc_full = 61'(tc_in) * 61'(x2_in);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      ps     <= ps_full[60:30];
      pc     <= pc_full[60:30];
      x2_mid <= x2_in;
      as_mid <= as_in;
      ac_mid <= ac_in;
    end
  end

  assign qs_full = 63'(ps) * 63'(MS);
  assign qc_full = 63'(pc) * 63'(MC);
  assign qs      = 31'(qs_full >> (30 + LS));
  assign qc      = 31'(qc_full >> (30 + LC));

  always_ff @(posedge clk) begin
    if (en[1]) begin
      ts_out <= qs;
      tc_out <= qc;
      x2_out <= x2_mid;
      if (NEG) begin
        as_out <= as_mid - signed'({1'b0, qs});
        ac_out <= ac_mid - signed'({1'b0, qc});
      end else begin
        as_out <= as_mid + signed'({1'b0, qs});
        ac_out <= ac_mid + signed'({1'b0, qc});
      end
    end
  end

endmodule

>>> hw/rtl/pafk_sincos.sv
module pafk_sincos (
  input  logic                                     clk,
  input  logic [pafk_pkg::SC_STAGES-1:0]           en,
  input  logic signed [pafk_pkg::SUM_ANGLE_W-1:0]  angle,
  output logic signed [pafk_pkg::TRIG_W-1:0]       sin_val,
  output logic signed [pafk_pkg::TRIG_W-1:0]       cos_val
);
  import pafk_pkg::*;

  localparam int NSTEP = 6;
  localparam int GS    = 4 + 2 * NSTEP;

  logic signed [48:0] prod;
  logic signed [48:0] prod_rnd;
  logic [31:0]        phase;
  logic [29:0]        q;
  logic [29:0]        r;
  logic [61:0]        x_full;
  logic [29:0]        x;
  logic [59:0]        x2_full;
  octant_t            side [1:GS];

  logic [30:0]        ts [0:NSTEP];
  logic [30:0]        tc [0:NSTEP];
  logic [29:0]        x2 [0:NSTEP];
  logic signed [31:0] acs [0:NSTEP];
  logic signed [31:0] acc [0:NSTEP];

  logic signed [31:0] rs_sum, rc_sum;
  logic signed [TRIG_W-1:0] s0, c0;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      prod <= 49'(angle) * signed'({17'd0, INV_PI_Q32});
    end
  end

  // Phase in units of 2^-32 turn, rounded half up.
  assign prod_rnd = prod + (49'sd1 <<< ANGLE_FRAC_BITS);
  assign phase    = prod_rnd[ANGLE_FRAC_BITS+32:ANGLE_FRAC_BITS+1];
  assign q        = phase[29:0];

  always_ff @(posedge clk) begin
    if (en[1]) begin
      side[1].quad <= phase[31:30];
      side[1].swap <= q[29];
      r            <= q[29] ? 30'(31'h4000_0000 - 31'(q)) : q;
    end
  end

  for (genvar i = 2; i <= GS; i++) begin : g_side
    always_ff @(posedge clk) begin
      if (en[i]) begin
        side[i] <= side[i-1];
      end
    end
  end

  assign x_full = 62'(r) * 62'(PI_Q30);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      x <= x_full[60:31];
    end
  end

  assign x2_full = 60'(x) * 60'(x);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      x2[0]  <= x2_full[59:30];
      ts[0]  <= {1'b0, x};
      tc[0]  <= ONE_Q30;
      acs[0] <= signed'({2'b00, x});
      acc[0] <= signed'({1'b0, ONE_Q30});
    end
  end

  for (genvar k = 1; k <= NSTEP; k++) begin : g_step
    pafk_taylor_step #(
      .DS  ((2 * k) * (2 * k + 1)),
      .DC  ((2 * k - 1) * (2 * k)),
      .NEG (1'((k % 2)))
    ) u_step (
      .clk    (clk),
      .en     (en[2*k+3:2*k+2]),
      .ts_in  (ts[k-1]),
      .tc_in  (tc[k-1]),
      .x2_in  (x2[k-1]),
      .as_in  (acs[k-1]),
      .ac_in  (acc[k-1]),
      .ts_out (ts[k]),
      .tc_out (tc[k]),
      .x2_out (x2[k]),
      .as_out (acs[k]),
      .ac_out (acc[k])
    );
  end

  // Round the Q30 series to Q16; past the quadrant midpoint sine and cosine trade places.
  assign rs_sum = acs[NSTEP] + 32'sd8192;
  assign rc_sum = acc[NSTEP] + 32'sd8192;

  always_ff @(posedge clk) begin
    if (en[GS]) begin
      if (side[GS-1].swap) begin
        s0 <= TRIG_W'(rc_sum >>> 14);
        c0 <= TRIG_W'(rs_sum >>> 14);
      end else begin
        s0 <= TRIG_W'(rs_sum >>> 14);
        c0 <= TRIG_W'(rc_sum >>> 14);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[GS+1]) begin
      case (side[GS].quad)
        2'd0: begin
          sin_val <= s0;
          cos_val <= c0;
        end
        2'd1: begin
          sin_val <= c0;
          cos_val <= -s0;
        end
        2'd2: begin
          sin_val <= -s0;
          cos_val <= -c0;
        end
        default: begin
          sin_val <= -c0;
          cos_val <= s0;
        end
      endcase
    end
  end

endmodule

>>> hw/rtl/planar_arm_forward_kinematics_core.sv
// Forward kinematics of a three-link planar arm.
// Input stream s_*: one beat carries three joint angles (2^-12 rad each,
// relative to the previous link). Output stream m_*: one beat per input
// beat with the end point x and y (2^-16 m) and the tool orientation
// (2^-6 degree), in input order.
// The user must write link lengths on the cfg_* port (index 0..2, unsigned,
// 2^-16 m) only while the block is idle; the block does not enforce this.
// A write to index 3 is ignored. The pipeline takes one beat per cycle
// unless m_tready stalls it: each of the three sine/cosine lanes is
// an 18-stage chain of 32x32 multipliers (phase, Taylor terms, fold-back),
// followed by a product stage and a sum-and-round stage.
// Reset clears the link lengths and empties the pipeline. When the receiver
// holds m_tready low, items pack into empty stages and s_tready falls only
// once every stage is full; nothing is dropped or repeated.
module planar_arm_forward_kinematics_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // first_joint_angle, second_joint_angle, third_joint_angle, zero pad
  input  logic [47:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // x_position, y_position, tool_orientation, zero pad
  output logic [55:0] m_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import pafk_pkg::*;

  localparam int LAST = PIPE_DEPTH - 1;
  localparam int PSTG = SC_STAGES + 1;

  logic [PIPE_DEPTH-1:0] en;
  logic [PIPE_DEPTH-1:0] valid;

  logic [LEN_W-1:0] link_len [0:NUM_LINKS-1];

  logic signed [SUM_ANGLE_W-1:0] ang_in [0:NUM_LINKS-1];
  logic signed [SUM_ANGLE_W-1:0] ang    [0:NUM_LINKS-1];
  logic signed [TRIG_W-1:0]      sn     [0:NUM_LINKS-1];
  logic signed [TRIG_W-1:0]      cs     [0:NUM_LINKS-1];
  logic signed [34:0]            px     [0:NUM_LINKS-1];
  logic signed [34:0]            py     [0:NUM_LINKS-1];

  logic signed [44:0]         ori_prod;
  logic signed [44:0]         ori_rnd;
  logic [ORIENT_W-1:0]        ori_d [2:LAST];
  logic signed [36:0]         sx, sy;
  logic [POS_W-1:0]           x_pos, y_pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_LINKS; i++) begin
        link_len[i] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FIRST_LINK:  link_len[0] <= cfg_data;
        REG_SECOND_LINK: link_len[1] <= cfg_data;
        REG_THIRD_LINK:  link_len[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  pafk_pipe_ctrl #(
    .DEPTH (PIPE_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .out_ready (m_tready),
    .en        (en),
    .valid     (valid)
  );

  assign s_tready = en[0];
  assign m_tvalid = valid[LAST];

  // Cumulative link angles.
  assign ang_in[0] = SUM_ANGLE_W'(signed'(s_tdata[14:0]));
  assign ang_in[1] = ang_in[0] + SUM_ANGLE_W'(signed'(s_tdata[29:15]));
  assign ang_in[2] = ang_in[1] + SUM_ANGLE_W'(signed'(s_tdata[44:30]));

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int i = 0; i < NUM_LINKS; i++) begin
        ang[i] <= ang_in[i];
      end
    end
  end

  for (genvar i = 0; i < NUM_LINKS; i++) begin : g_lane
    pafk_sincos u_sincos (
      .clk     (clk),
      .en      (en[SC_STAGES:1]),
      .angle   (ang[i]),
      .sin_val (sn[i]),
      .cos_val (cs[i])
    );

    always_ff @(posedge clk) begin
      if (en[PSTG]) begin
        px[i] <= signed'({19'd0, link_len[i]}) * 35'(cs[i]);
        py[i] <= signed'({19'd0, link_len[i]}) * 35'(sn[i]);
      end
    end
  end

  // Orientation is ready early and rides along the pipeline.
  always_ff @(posedge clk) begin
    if (en[1]) begin
      ori_prod <= 45'(ang[2]) * signed'({17'd0, DEG64_Q16});
    end
  end

  assign ori_rnd = ori_prod + (45'sd1 <<< (15 + ANGLE_FRAC_BITS));

  always_ff @(posedge clk) begin
    if (en[2]) begin
      ori_d[2] <= ori_rnd[ORIENT_W+16+ANGLE_FRAC_BITS-1:16+ANGLE_FRAC_BITS];
    end
  end

  for (genvar i = 3; i <= LAST; i++) begin : g_ori
    always_ff @(posedge clk) begin
      if (en[i]) begin
        ori_d[i] <= ori_d[i-1];
      end
    end
  end

  assign sx = 37'(px[0]) + 37'(px[1]) + 37'(px[2]) + 37'sd32768;
  assign sy = 37'(py[0]) + 37'(py[1]) + 37'(py[2]) + 37'sd32768;

  always_ff @(posedge clk) begin
    if (en[LAST]) begin
      x_pos <= sx[POS_W+15:16];
      y_pos <= sy[POS_W+15:16];
    end
  end

  assign m_tdata = {1'b0, ori_d[LAST], y_pos, x_pos};

  // An empty output stage always leaves room at the input.
  assert property (@(posedge clk) disable iff (rst) !valid[LAST] |-> s_tready)
    else $error("input stalled with an empty output stage");

  // A taken output beat frees the whole chain.
  assert property (@(posedge clk) disable iff (rst) m_tready |-> s_tready)
    else $error("input stalled while output is taken");

  // An accepted beat is in the first stage in the next cycle.
  assert property (@(posedge clk) disable iff (rst) s_tvalid && s_tready |=> valid[0])
    else $error("accepted beat lost at the first stage");

endmodule
